// ===== src/kmg_pkg.sv =====
package kmg_pkg;

    // Board geometry
    localparam int BOARD_SIDE   = 8;
    localparam int SQUARE_COUNT = BOARD_SIDE * BOARD_SIDE;
    localparam int IN_W         = 3;
    localparam int CRD_W        = ($clog2(BOARD_SIDE) > IN_W) ? $clog2(BOARD_SIDE) : IN_W;
    localparam int SQ_W         = $clog2(SQUARE_COUNT);
    localparam int PTR_W        = $clog2(SQUARE_COUNT + 1);
    localparam int DIST_W       = 7;
    localparam int CNT_W        = 6;
    localparam int NC_W         = CRD_W + 2;
    localparam int STEP_N       = 8;
    localparam int COUNT_MAX    = 63;

    localparam int STEP_COL [STEP_N] = '{-1, -1, 1, 1, -2, -2, 2, 2};
    localparam int STEP_ROW [STEP_N] = '{-2, 2, -2, 2, -1, 1, -1, 1};

    typedef struct packed {
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
    } t_coord;

    // distance store request
    typedef struct packed {
        logic              clear;
        logic              wr;
        logic [SQ_W-1:0]   wr_addr;
        logic [DIST_W-1:0] wr_data;
        logic              rd;
        logic [SQ_W-1:0]   rd_addr;
    } t_dist_req;

    // visit queue request and status
    typedef struct packed {
        logic   clear;
        logic   push;
        t_coord push_data;
        logic   pop;
    } t_q_req;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } t_q_stat;

    function automatic logic [SQ_W-1:0] sq_index(input t_coord c);
        return SQ_W'(int'(c.col) * BOARD_SIDE + int'(c.row));
    endfunction

endpackage

// ===== src/kmg_dist.sv =====
module kmg_dist import kmg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dist_req                i_req,
    output logic [DIST_W-1:0]        o_rd_data,
    output logic [SQUARE_COUNT-1:0]  o_visited
);

    logic [DIST_W-1:0]       r_mem [SQUARE_COUNT];
    logic [DIST_W-1:0]       r_rd_data;
    logic [SQUARE_COUNT-1:0] r_visited;
    logic [SQUARE_COUNT-1:0] wr_mark;

    assign wr_mark = i_req.wr ? (SQUARE_COUNT'(1) << i_req.wr_addr) : '0;

    // clear and seed mark land together at query start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
        end else if (i_req.clear) begin
            r_visited <= wr_mark;
        end else begin
            r_visited <= r_visited | wr_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_visited = r_visited;

endmodule

// ===== src/kmg_queue.sv =====
module kmg_queue import kmg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_req  i_req,
    output t_coord  o_rd_data,
    output t_q_stat o_stat
);

    t_coord           r_mem [SQUARE_COUNT];
    t_coord           r_rd_data;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [SQ_W-1:0]  wr_idx;

    // clear with push seeds entry zero
    assign wr_idx = i_req.clear ? '0 : r_tail[SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_req.clear) begin
            r_head <= '0;
            r_tail <= i_req.push ? PTR_W'(1) : '0;
        end else begin
            if (i_req.push) begin
                r_tail <= r_tail + PTR_W'(1);
            end
            if (i_req.pop) begin
                r_head <= r_head + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[wr_idx] <= i_req.push_data;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[r_head[SQ_W-1:0]];
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_stat.head = r_head;
    assign o_stat.tail = r_tail;

endmodule

// ===== src/knight_move_grid_bfs_unit.sv =====
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+-------------------------------
// query    | i_start_col, i_start_row, i_dest_col, i_dest_row | beat taken when start && !busy
// result   | o_move_count, o_reachable                      | beat valid for one cycle, o_done
//
// One query at a time. A query runs a breadth-first search: a seed step, then
// per popped square the pop, queue read and distance read states and, unless it
// is the target, the expand state, which enqueues one neighbor at a time until none
// is left or the queue is full; an off-board square answers in the cycle after its beat.
// While expanding, one push and one distance write per cycle set the pace.
// Reset clears the sequencer, queue pointers and visited bits; the receiver
// cannot stall, so o_done is a single-cycle strobe.
module knight_move_grid_bfs_unit import kmg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   i_start_col,
    input  logic [IN_W-1:0]   i_start_row,
    input  logic [IN_W-1:0]   i_dest_col,
    input  logic [IN_W-1:0]   i_dest_row,
    output logic              o_done,
    output logic [CNT_W-1:0]  o_move_count,
    output logic              o_reachable
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_QRD,
        S_DRD,
        S_EXP
    } t_state;

    t_state                  r_state, n_state;
    t_coord                  r_tgt, n_tgt;
    logic                    r_hit, n_hit;
    logic [STEP_N-1:0]       r_pend, n_pend;
    logic                    r_done, n_done;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_reach, n_reach;

    t_dist_req               dreq;
    t_q_req                  qreq;
    logic [DIST_W-1:0]       d_rd;
    logic [SQUARE_COUNT-1:0] visited;
    t_coord                  q_rd;
    t_q_stat                 qstat;

    t_coord                  seed;
    logic                    off_board;
    logic                    can_pop;
    logic                    q_full;

    // neighbor generation for the square being expanded
    t_coord                  nb     [STEP_N];
    logic [SQ_W-1:0]         nb_sq  [STEP_N];
    logic [STEP_N-1:0]       elig;
    logic [STEP_N-1:0]       pick;
    logic [$clog2(STEP_N)-1:0] pick_k;
    logic                    any_elig;
    logic [DIST_W-1:0]       next_dist;

    kmg_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dreq),
        .o_rd_data (d_rd),
        .o_visited (visited)
    );

    kmg_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (qreq),
        .o_rd_data (q_rd),
        .o_stat    (qstat)
    );

    assign seed.col  = CRD_W'(i_start_col);
    assign seed.row  = CRD_W'(i_start_row);
    assign off_board = (int'(i_start_col) >= BOARD_SIDE) || (int'(i_start_row) >= BOARD_SIDE)
                    || (int'(i_dest_col) >= BOARD_SIDE) || (int'(i_dest_row) >= BOARD_SIDE);
    assign can_pop   = qstat.head < qstat.tail;
    assign q_full    = qstat.tail == PTR_W'(SQUARE_COUNT);
    assign next_dist = d_rd + DIST_W'(1);

    // eight candidates off the current square (held in the queue read register)
    always_comb begin
        logic signed [NC_W-1:0] nc;
        logic signed [NC_W-1:0] nr;
        logic                   on_b;
        for (int k = 0; k < STEP_N; k++) begin
            nc = $signed({2'b00, q_rd.col}) + NC_W'(STEP_COL[k]);
            nr = $signed({2'b00, q_rd.row}) + NC_W'(STEP_ROW[k]);
            on_b = !nc[NC_W-1] && !nr[NC_W-1]
                && (nc < $signed(NC_W'(BOARD_SIDE))) && (nr < $signed(NC_W'(BOARD_SIDE)));
            nb[k].col = nc[CRD_W-1:0];
            nb[k].row = nr[CRD_W-1:0];
            nb_sq[k]  = sq_index(nb[k]);
            elig[k]   = r_pend[k] && on_b && !visited[nb_sq[k]];
        end
    end

    // lowest candidate first keeps the enqueue order
    always_comb begin
        logic found;
        found  = 1'b0;
        pick   = '0;
        pick_k = '0;
        for (int k = 0; k < STEP_N; k++) begin
            if (elig[k] && !found) begin
                found   = 1'b1;
                pick[k] = 1'b1;
                pick_k  = ($clog2(STEP_N))'(k);
            end
        end
        any_elig = found;
    end

    always_comb begin
        n_state = r_state;
        n_tgt   = r_tgt;
        n_hit   = r_hit;
        n_pend  = r_pend;
        n_done  = 1'b0;
        n_count = r_count;
        n_reach = r_reach;
        dreq    = '0;
        qreq    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (off_board) begin
                        n_done  = 1'b1;
                        n_count = '0;
                        n_reach = 1'b0;
                    end else begin
                        n_tgt.col      = CRD_W'(i_dest_col);
                        n_tgt.row      = CRD_W'(i_dest_row);
                        dreq.clear     = 1'b1;
                        dreq.wr        = 1'b1;
                        dreq.wr_addr   = sq_index(seed);
                        dreq.wr_data   = '0;
                        qreq.clear     = 1'b1;
                        qreq.push      = 1'b1;
                        qreq.push_data = seed;
                        n_state        = S_POP;
                    end
                end
            end
            S_POP: begin
                if (can_pop) begin
                    qreq.pop = 1'b1;
                    n_state  = S_QRD;
                end else begin
                    n_done  = 1'b1;
                    n_count = '0;
                    n_reach = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_QRD: begin
                dreq.rd      = 1'b1;
                dreq.rd_addr = sq_index(q_rd);
                n_hit        = q_rd == r_tgt;
                n_pend       = '1;
                n_state      = S_DRD;
            end
            S_DRD: begin
                if (r_hit) begin
                    n_done  = 1'b1;
                    n_count = (int'(d_rd) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : d_rd[CNT_W-1:0];
                    n_reach = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (any_elig && !q_full) begin
                    qreq.push      = 1'b1;
                    qreq.push_data = nb[pick_k];
                    dreq.wr        = 1'b1;
                    dreq.wr_addr   = nb_sq[pick_k];
                    dreq.wr_data   = next_dist;
                    n_pend         = r_pend & ~pick;
                    if (((elig & ~pick) == '0) || (qstat.tail == PTR_W'(SQUARE_COUNT - 1))) begin
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_tgt   <= n_tgt;
        r_hit   <= n_hit;
        r_pend  <= n_pend;
        r_count <= n_count;
        r_reach <= n_reach;
    end

    assign busy         = r_state != S_IDLE;
    assign o_done       = r_done;
    assign o_move_count = r_count;
    assign o_reachable  = r_reach;

`ifndef SYNTHESIS
    // a result always closes the search
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while search still running");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_reachable) |-> (o_move_count == '0))
        else $error("unreachable result with nonzero move count");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted query neither answered nor searching");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.head <= qstat.tail) && (qstat.tail <= PTR_W'(SQUARE_COUNT)))
        else $error("visit queue pointers out of order");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qreq.push && !qreq.clear) |-> !q_full)
        else $error("push into full visit queue");
`endif

endmodule

// ===== tb/sv/tb_knight_move_grid_bfs_unit.sv =====
// Knight-distance BFS unit bench: queued query driver, strobe monitor, scoreboard
module tb_knight_move_grid_bfs_unit;
    import kmg_pkg::*;

    // no-accept watchdog, post-drain settle window
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYC   = 300;
    localparam int RANDOM_BEATS = 550;

    typedef struct {
        logic [IN_W-1:0] sc;
        logic [IN_W-1:0] sr;
        logic [IN_W-1:0] dc;
        logic [IN_W-1:0] dr;
        bit              drain;   // hold this beat until all answers are back
    } t_query;

    typedef struct {
        logic [CNT_W-1:0] move_count;
        logic             reachable;
    } t_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [IN_W-1:0]  i_start_col = '0;
    logic [IN_W-1:0]  i_start_row = '0;
    logic [IN_W-1:0]  i_dest_col = '0;
    logic [IN_W-1:0]  i_dest_row = '0;
    logic             o_done;
    logic [CNT_W-1:0] o_move_count;
    logic             o_reachable;

    t_query  pending_queries [$];
    t_answer expected_answers [$];
    t_query  driven_query;
    int      total_beats;
    int      loaded_beats = 0;
    int      mismatch_cnt = 0;
    int      stall_cyc = 0;

    knight_move_grid_bfs_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_start_col  (i_start_col),
        .i_start_row  (i_start_row),
        .i_dest_col   (i_dest_col),
        .i_dest_row   (i_dest_row),
        .o_done       (o_done),
        .o_move_count (o_move_count),
        .o_reachable  (o_reachable)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor: plain BFS over the eight knight jumps. Squares are
    // numbered col*BOARD_SIDE+row, search ends when the target is popped.
    // Off-board coordinates (only possible on boards under 8) and an
    // exhausted queue both answer count 0, not reachable.
    // ------------------------------------------------------------------
    function automatic t_answer knight_distance(input t_query q);
        int      sq_dist [SQUARE_COUNT];
        bit      seen [SQUARE_COUNT];
        int      fifo [SQUARE_COUNT];
        int      head, tail, cur, target, cc, cr, nc, nr, nx, jc, jr;
        t_answer a;
        a.move_count = '0;
        a.reachable  = 1'b0;
        if (int'(q.sc) >= BOARD_SIDE || int'(q.sr) >= BOARD_SIDE ||
            int'(q.dc) >= BOARD_SIDE || int'(q.dr) >= BOARD_SIDE) begin
            return a;
        end
        for (int i = 0; i < SQUARE_COUNT; i++) begin
            sq_dist[i] = 0;
            seen[i] = 1'b0;
            fifo[i] = 0;
        end
        head   = 0;
        tail   = 0;
        target = int'(q.dc) * BOARD_SIDE + int'(q.dr);
        cur    = int'(q.sc) * BOARD_SIDE + int'(q.sr);
        seen[cur]  = 1'b1;
        fifo[tail] = cur;
        tail++;
        while (head < tail) begin
            cur = fifo[head];
            head++;
            if (cur == target) begin
                a.move_count = (sq_dist[cur] > COUNT_MAX) ? CNT_W'(COUNT_MAX)
                                                          : CNT_W'(sq_dist[cur]);
                a.reachable  = 1'b1;
                return a;
            end
            cc = cur / BOARD_SIDE;
            cr = cur % BOARD_SIDE;
            for (int k = 0; k < 8; k++) begin
                // jump table: cols -1,-1,1,1,-2,-2,2,2 / rows -2,2,-2,2,-1,1,-1,1
                jc = (k < 4) ? ((k < 2) ? -1 : 1) : ((k < 6) ? -2 : 2);
                jr = (k < 4) ? ((k % 2) ? 2 : -2) : ((k % 2) ? 1 : -1);
                nc = cc + jc;
                nr = cr + jr;
                if (nc >= 0 && nc < BOARD_SIDE && nr >= 0 && nr < BOARD_SIDE) begin
                    nx = nc * BOARD_SIDE + nr;
                    if (!seen[nx] && tail < SQUARE_COUNT) begin
                        seen[nx]    = 1'b1;
                        sq_dist[nx] = (sq_dist[cur] + 1) & 127;
                        fifo[tail]  = nx;
                        tail++;
                    end
                end
            end
        end
        return a;
    endfunction

    // sender gap chance in percent per free slot: light, heavy, then none
    function automatic int gap_pct(input int loaded);
        if (loaded < total_beats / 3)
            return 6;
        if (loaded < (2 * total_beats) / 3)
            return 73;
        return 0;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_cnt++;
    endtask

    task automatic add_query(input int sc, input int sr, input int dc, input int dr,
                             input bit drain);
        t_query q;
        q.sc    = IN_W'(sc);
        q.sr    = IN_W'(sr);
        q.dc    = IN_W'(dc);
        q.dr    = IN_W'(dr);
        q.drain = drain;
        pending_queries.push_back(q);
    endtask

    // ------------------------------------------------------------------
    // Driver. A beat is taken at an edge with start && !busy; its answer
    // is predicted right then. Once the slot frees, the next query goes
    // out unless a random gap is taken or a drain waits on answers. start
    // gets at most one NBA per edge so back-to-back beats keep it high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_query nxt;
        bit     send;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_answers.push_back(knight_distance(driven_query));
            end
            if (!start || !busy) begin
                send = 1'b0;
                if (pending_queries.size() != 0) begin
                    nxt  = pending_queries[0];
                    send = !(nxt.drain && expected_answers.size() != 0) &&
                           ($urandom_range(99) >= gap_pct(loaded_beats));
                end
                if (send) begin
                    nxt = pending_queries.pop_front();
                    loaded_beats++;
                    driven_query <= nxt;
                    i_start_col  <= nxt.sc;
                    i_start_row  <= nxt.sr;
                    i_dest_col   <= nxt.dc;
                    i_dest_row   <= nxt.dr;
                    start        <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. o_done is a one-cycle strobe; the result beat is taken at
    // the edge closing that cycle and checked against the oldest answer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing pending: count %0d reach %0b",
                                        o_move_count, o_reachable));
            end else begin
                exp_a = expected_answers.pop_front();
                if (o_move_count !== exp_a.move_count)
                    flag_mismatch($sformatf("move_count got %0d exp %0d",
                                            o_move_count, exp_a.move_count));
                if (o_reachable !== exp_a.reachable)
                    flag_mismatch($sformatf("reachable got %0b exp %0b",
                                            o_reachable, exp_a.reachable));
            end
        end
    end

    // watchdog: any accepted beat, either side, resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                stall_cyc <= 0;
            end else if (stall_cyc >= STALL_LIMIT) begin
                $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_cyc <= stall_cyc + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int sc, sr;
        // directed: same square, corner to corner, short hops, corner
        // diagonal (4 moves), edge neighbors. Unreachable, off-board and
        // saturation cases cannot occur on an 8x8 board with 3-bit fields.
        add_query(0, 0, 0, 0, 1'b0);
        add_query(7, 7, 7, 7, 1'b0);
        add_query(3, 4, 3, 4, 1'b0);
        add_query(0, 0, 7, 7, 1'b0);
        add_query(7, 7, 0, 0, 1'b0);
        add_query(0, 7, 7, 0, 1'b0);
        add_query(7, 0, 0, 7, 1'b0);
        add_query(0, 0, 1, 2, 1'b0);
        add_query(0, 0, 2, 1, 1'b0);
        add_query(0, 0, 1, 1, 1'b0);
        add_query(7, 7, 6, 6, 1'b0);
        add_query(3, 3, 4, 4, 1'b0);
        add_query(0, 0, 0, 1, 1'b0);
        add_query(7, 0, 7, 7, 1'b0);
        add_query(5, 2, 2, 5, 1'b0);
        // random: mostly uniform squares, some same-square queries;
        // drain points at the first random beat and midway
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            sc = $urandom_range(7);
            sr = $urandom_range(7);
            if ($urandom_range(9) == 0)
                add_query(sc, sr, sc, sr, (i == 0) || (i == RANDOM_BEATS / 2));
            else
                add_query(sc, sr, $urandom_range(7), $urandom_range(7),
                          (i == 0) || (i == RANDOM_BEATS / 2));
        end
        total_beats = pending_queries.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_queries.size() != 0 || start || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (expected_answers.size() != 0)
            flag_mismatch($sformatf("%0d answers never came back", expected_answers.size()));
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/kmg_pkg.sv
src/kmg_dist.sv
src/kmg_queue.sv
src/knight_move_grid_bfs_unit.sv
tb/sv/tb_knight_move_grid_bfs_unit.sv
